// ----- design/stid_pkg.sv -----
// stid_pkg: shared types and constants for the sorted key table
// used by the table cells, the top level and the port checker
package stid_pkg;

  // fixed field widths
  localparam int KEY_W  = 32;
  localparam int CNT_W  = 5;
  localparam int POS_W  = 4;
  localparam int STAT_W = 2;

  // largest value the count and capacity registers can hold
  localparam int CNT_MAX = (1 << CNT_W) - 1;

  // capacity register value after reset
  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(16);

  // operation codes
  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_DELETE = 1'b1
  } cmd_e;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_INSERTED  = 2'd0,
    ST_FULL      = 2'd1,
    ST_DELETED   = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  // update strobes broadcast to every cell of the chain
  typedef struct packed {
    logic ins;  // shift up from the insert slot, place the new key
    logic del;  // shift down from the hit slot
  } cell_ctrl_t;

endpackage

// ----- design/stid_cell.sv -----
// stid_cell: one slot of the sorted key table chain
// holds a key, registers its compare flags and shifts with its neighbors
// depends on stid_pkg
module stid_cell (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // compare against the incoming key
  input  logic                               cmp_en_i,
  input  logic signed [stid_pkg::KEY_W-1:0]  cmp_key_i,
  input  logic                               valid_i,
  // update
  input  stid_pkg::cell_ctrl_t               ctrl_i,
  input  logic [stid_pkg::KEY_W-1:0]         new_key_i,
  input  logic                               prev_le_i,
  input  logic [stid_pkg::KEY_W-1:0]         left_key_i,
  input  logic [stid_pkg::KEY_W-1:0]         right_key_i,
  // state seen by the neighbors and the top level
  output logic [stid_pkg::KEY_W-1:0]         key_o,
  output logic                               le_o,
  output logic                               lt_o,
  output logic                               eq_o
);
  import stid_pkg::*;

  logic [KEY_W-1:0] key_q, key_d;
  logic             le_q, lt_q, eq_q;

  // compare flags, masked by entry validity
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      le_q <= 1'b0;
      lt_q <= 1'b0;
      eq_q <= 1'b0;
    end else if (cmp_en_i) begin
      le_q <= valid_i && ($signed(key_q) <= cmp_key_i);
      lt_q <= valid_i && ($signed(key_q) <  cmp_key_i);
      eq_q <= valid_i && ($signed(key_q) == cmp_key_i);
    end
  end

  // insert: cells above the slot take the left key, the slot takes the new key
  // delete: cells from the hit upward take the right key
  always_comb begin
    key_d = key_q;
    if (ctrl_i.ins && !le_q) begin
      key_d = prev_le_i ? new_key_i : left_key_i;
    end else if (ctrl_i.del && !lt_q) begin
      key_d = right_key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o = key_q;
  assign le_o  = le_q;
  assign lt_o  = lt_q;
  assign eq_o  = eq_q;

endmodule

// ----- design/sorted_table_insert_delete.sv -----
// sorted_table_insert_delete: sorted signed key table with insert and delete
// operation: the per-cell compare is registered, then the neighbor shift and the
//   result register are updated; a new command is taken only once the one before
//   it has shifted; a pending result stalls the shift step
// reset: count cleared, capacity set to 16, key storage left undefined
// depends on stid_pkg and stid_cell
module sorted_table_insert_delete #(
  parameter int DEPTH = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [stid_pkg::CNT_W-1:0]         cfg_data_i,
  // command channel
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               cmd_i,
  input  logic signed [stid_pkg::KEY_W-1:0]  key_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [stid_pkg::STAT_W-1:0]        status_o,
  output logic [stid_pkg::CNT_W-1:0]         entry_count_o,
  output logic [stid_pkg::POS_W-1:0]         position_o
);
  import stid_pkg::*;

  localparam int CAP_MAX = (DEPTH < CNT_MAX) ? DEPTH : CNT_MAX;

  logic             busy_q;
  cmd_e             cmd_q;
  logic [KEY_W-1:0] key_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] cap_q;
  logic             out_valid_q;
  status_e          status_q, status_d;
  logic [CNT_W-1:0] ecount_q;
  logic [POS_W-1:0] pos_q, pos_d;

  logic             accept, commit, full, found;
  logic [CNT_W-1:0] eff_cap;
  cell_ctrl_t       ctrl;

  logic [KEY_W-1:0] key_w   [DEPTH];
  logic [DEPTH-1:0] valid_w, le_w, lt_w, eq_w;
  logic [DEPTH-1:0] ins_hot, del_hot;
  logic [POS_W-1:0] ins_pos, del_pos;

  // handshakes
  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !busy_q;
  assign accept      = in_valid_i && in_ready_o;
  assign commit      = busy_q && (!out_valid_q || out_ready_i);

  // capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_valid_i) begin
      cap_q <= cfg_data_i;
    end
  end

  // operation held between compare and shift
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (accept) begin
      busy_q <= 1'b1;
    end else if (commit) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_e'(cmd_i);
      key_q <= key_i;
    end
  end

  // cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i <= CNT_MAX) begin : g_valid
      assign valid_w[i] = count_q > CNT_W'(i);
    end else begin : g_never
      assign valid_w[i] = 1'b0;
    end

    stid_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmp_en_i    (accept),
      .cmp_key_i   (key_i),
      .valid_i     (valid_w[i]),
      .ctrl_i      (ctrl),
      .new_key_i   (key_q),
      .prev_le_i   ((i == 0) ? 1'b1 : le_w[(i == 0) ? 0 : i-1]),
      .left_key_i  ((i == 0) ? key_q : key_w[(i == 0) ? 0 : i-1]),
      .right_key_i (key_w[(i == DEPTH-1) ? i : i+1]),
      .key_o       (key_w[i]),
      .le_o        (le_w[i]),
      .lt_o        (lt_w[i]),
      .eq_o        (eq_w[i])
    );

    // boundary of the thermometer flags marks the slot touched
    if (i == 0) begin : g_first
      assign ins_hot[i] = !le_w[i];
      assign del_hot[i] = !lt_w[i];
    end else begin : g_rest
      assign ins_hot[i] = !le_w[i] && le_w[i-1];
      assign del_hot[i] = !lt_w[i] && lt_w[i-1];
    end
  end

  // slot encoders, position masked to its field width
  always_comb begin
    ins_pos = '0;
    del_pos = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (ins_hot[i]) ins_pos = ins_pos | POS_W'(i);
      if (del_hot[i]) del_pos = del_pos | POS_W'(i);
    end
  end

  assign found   = |(del_hot & eq_w);
  assign eff_cap = (cap_q > CNT_W'(CAP_MAX)) ? CNT_W'(CAP_MAX) : cap_q;
  assign full    = count_q >= eff_cap;

  assign ctrl.ins = commit && (cmd_q == CMD_INSERT) && !full;
  assign ctrl.del = commit && (cmd_q == CMD_DELETE) && found;

  // result and next count
  always_comb begin
    count_d  = count_q;
    status_d = ST_FULL;
    pos_d    = '0;
    if (cmd_q == CMD_INSERT) begin
      if (!full) begin
        count_d  = count_q + CNT_W'(1);
        status_d = ST_INSERTED;
        pos_d    = ins_pos;
      end
    end else begin
      status_d = ST_NOT_FOUND;
      if (found) begin
        count_d  = count_q - CNT_W'(1);
        status_d = ST_DELETED;
        pos_d    = del_pos;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (commit) begin
      count_q <= count_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      status_q <= status_d;
      ecount_q <= count_d;
      pos_q    <= pos_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign entry_count_o = ecount_q;
  assign position_o    = pos_q;

endmodule

// ----- design/stid_checker.sv -----
// stid_checker: port-level checks on the sorted key table results
// attached to sorted_table_insert_delete by the bind below; depends on stid_pkg
module stid_checker #(
  parameter int DEPTH = 16
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [stid_pkg::STAT_W-1:0] status_o,
  input logic [stid_pkg::CNT_W-1:0]  entry_count_o,
  input logic [stid_pkg::POS_W-1:0]  position_o
);
  import stid_pkg::*;

  localparam int CAP_MAX = (DEPTH < CNT_MAX) ? DEPTH : CNT_MAX;

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(entry_count_o) && $stable(position_o))
    else $error("result changed while stalled");

  // count never exceeds the table depth
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> entry_count_o <= CNT_W'(CAP_MAX))
    else $error("entry count above depth");

  // nothing changed means position zero
  a_pos_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_FULL || status_o == ST_NOT_FOUND)
      |-> position_o == '0)
    else $error("nonzero position without a change");

  // an inserted key sits below the new count
  a_ins_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_INSERTED
      |-> entry_count_o != '0 && CNT_W'(position_o) < entry_count_o)
    else $error("insert position outside the table");

endmodule

bind sorted_table_insert_delete stid_checker #(.DEPTH(DEPTH)) u_stid_checker (.*);

// ----- dv/sorted_table_insert_delete_tb.sv -----
`timescale 1ns / 1ps
// sorted_table_insert_delete_tb: self-checking bench for the sorted key table
// drives insert/delete transactions and capacity writes, predicts each result
// depends on stid_pkg and sorted_table_insert_delete
module sorted_table_insert_delete_tb;
  import stid_pkg::*;

  localparam int TABLE_DEPTH    = 16;
  localparam int MAX_GAP        = 12;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int NUM_PHASES     = 10;
  localparam int OPS_PER_PHASE  = 60;
  localparam int POOL_SIZE      = 6;
  localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

  // one pending command and the idle cycles before it is offered
  typedef struct {
    cmd_e                     op;
    logic signed [KEY_W-1:0]  key;
    int unsigned              gap;
  } table_cmd_t;

  // one predicted result
  typedef struct {
    status_e           status;
    logic [CNT_W-1:0]  count;
    logic [POS_W-1:0]  pos;
  } table_result_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [CNT_W-1:0]         cfg_data_i = '0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic                     cmd_i = 1'b0;
  logic signed [KEY_W-1:0]  key_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic [STAT_W-1:0]        status_o;
  logic [CNT_W-1:0]         entry_count_o;
  logic [POS_W-1:0]         position_o;

  // shadow copy of the table and its capacity register
  logic signed [KEY_W-1:0]  shadow_keys [TABLE_DEPTH];
  int                       shadow_count = 0;
  logic [CNT_W-1:0]         shadow_cap = CAP_RESET;

  table_cmd_t               pending_cmds [$];
  table_result_t            expected_results [$];
  logic signed [KEY_W-1:0]  key_pool [POOL_SIZE];

  int  phase_cap [NUM_PHASES]     = '{31, 16, 3, 16, 1, 5, 0, 31, 9, 16};
  int  phase_ins_pct [NUM_PHASES] = '{80, 70, 45, 60, 55, 50, 50, 85, 40, 30};

  logic         cmd_taken = 1'b0;
  logic         res_taken = 1'b0;
  bit           tx_idle = 1'b1;
  bit           rx_burst = 1'b0;
  int unsigned  tx_wait = 0;
  int unsigned  rx_wait = 0;
  int unsigned  rx_draw;
  int           idle_cycles = 0;
  int           mismatch_count = 0;

  sorted_table_insert_delete #(
    .DEPTH(TABLE_DEPTH)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cmd_i         (cmd_i),
    .key_i         (key_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .entry_count_o (entry_count_o),
    .position_o    (position_o)
  );

  // clock
  always #6 clk_i = ~clk_i;

  // apply one insert or delete to the shadow table and return its result
  function automatic table_result_t predict_table_op(input cmd_e op,
                                                     input logic signed [KEY_W-1:0] k);
    table_result_t res;
    int            room;
    int            slot;
    int            hit;
    res.status = ST_NOT_FOUND;
    res.pos    = '0;
    if (op == CMD_INSERT) begin
      room = (int'(shadow_cap) > TABLE_DEPTH) ? TABLE_DEPTH : int'(shadow_cap);
      if (shadow_count >= room) begin
        res.status = ST_FULL;
      end else begin
        // new key goes after every entry that is smaller or equal
        slot = 0;
        for (int i = 0; i < shadow_count; i++) begin
          if (shadow_keys[i] <= k) slot = i + 1;
        end
        for (int i = shadow_count; i > slot; i--) begin
          shadow_keys[i] = shadow_keys[i-1];
        end
        shadow_keys[slot] = k;
        shadow_count++;
        res.status = ST_INSERTED;
        res.pos    = POS_W'(slot);
      end
    end else begin
      // lowest equal entry is removed
      hit = -1;
      for (int i = 0; i < shadow_count; i++) begin
        if (hit < 0 && shadow_keys[i] == k) hit = i;
      end
      if (hit >= 0) begin
        for (int i = hit; i + 1 < shadow_count; i++) begin
          shadow_keys[i] = shadow_keys[i+1];
        end
        shadow_count--;
        res.status = ST_DELETED;
        res.pos    = POS_W'(hit);
      end
    end
    res.count = CNT_W'(shadow_count);
    return res;
  endfunction

  // queue one command, with a random gap unless the sender runs back to back
  function automatic void queue_table_op(input cmd_e op, input logic signed [KEY_W-1:0] k);
    table_cmd_t c;
    c.op  = op;
    c.key = k;
    c.gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
    pending_cmds.push_back(c);
  endfunction

  // capacity write transaction, only issued while the table is idle
  task automatic write_capacity(input logic [CNT_W-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    shadow_cap = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // hold off until every queued command has produced its result
  task automatic wait_table_drained();
    while (pending_cmds.size() != 0 || in_valid_i || expected_results.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // command driver: offers the head of the queue after its gap
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || cmd_taken)) begin
      if (pending_cmds.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if (tx_wait < pending_cmds[0].gap) begin
        tx_wait++;
        in_valid_i <= 1'b0;
      end else begin
        tx_wait = 0;
        in_valid_i <= 1'b1;
        cmd_i      <= pending_cmds[0].op;
        key_i      <= pending_cmds[0].key;
        void'(pending_cmds.pop_front());
      end
    end
  end

  // result ready: new stall drawn after each accepted result
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_ready_i && res_taken) begin
        rx_draw = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
        rx_wait     <= rx_draw;
        out_ready_i <= (rx_draw == 0);
      end else if (!out_ready_i) begin
        if (rx_wait == 0) out_ready_i <= 1'b1;
        else rx_wait <= rx_wait - 1;
      end
    end
  end

  // monitor: check results against the oldest prediction, then predict new commands
  always @(posedge clk_i) begin
    table_result_t want;
    cmd_taken <= rst_ni && in_valid_i && in_ready_o;
    res_taken <= rst_ni && out_valid_o && out_ready_i;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("result with nothing pending: status %0d count %0d position %0d",
                 status_o, entry_count_o, position_o);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          if (status_o !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status_o);
            mismatch_count++;
          end
          if (entry_count_o !== want.count) begin
            $error("entry_count: expected %0d, actual %0d", want.count, entry_count_o);
            mismatch_count++;
          end
          if (position_o !== want.pos) begin
            $error("position: expected %0d, actual %0d", want.pos, position_o);
            mismatch_count++;
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        expected_results.push_back(predict_table_op(cmd_e'(cmd_i), key_i));
      end
    end
  end

  // watchdog on cycles with no transaction on any channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
        $error("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // stimulus sequence
  initial begin
    cmd_e                     op;
    logic signed [KEY_W-1:0]  k;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // capacity zero: insert is refused, delete on an empty table misses
    write_capacity(CNT_W'(0));
    queue_table_op(CMD_INSERT, 32'sd5);
    queue_table_op(CMD_DELETE, 32'sd5);
    wait_table_drained();

    // capacity above depth, key extremes, duplicates and misses
    write_capacity(CNT_W'(CNT_MAX));
    queue_table_op(CMD_INSERT, 32'sd0);
    queue_table_op(CMD_INSERT, KEY_MAX);
    queue_table_op(CMD_INSERT, KEY_MIN);
    queue_table_op(CMD_INSERT, -32'sd1);
    queue_table_op(CMD_INSERT, 32'sd0);
    queue_table_op(CMD_INSERT, 32'sd1);
    queue_table_op(CMD_DELETE, 32'sd0);
    queue_table_op(CMD_DELETE, 32'sd0);
    queue_table_op(CMD_DELETE, 32'sd0);
    queue_table_op(CMD_DELETE, KEY_MIN);
    queue_table_op(CMD_DELETE, KEY_MAX);
    queue_table_op(CMD_INSERT, 32'sh5555_5555);
    queue_table_op(CMD_INSERT, 32'shaaaa_aaaa);
    queue_table_op(CMD_DELETE, -32'sd1);
    queue_table_op(CMD_DELETE, 32'sd1);
    queue_table_op(CMD_DELETE, 32'sh5555_5555);
    queue_table_op(CMD_DELETE, 32'shaaaa_aaaa);
    queue_table_op(CMD_DELETE, KEY_MAX);
    wait_table_drained();

    // random phases: small key pool so deletes hit and duplicates build up
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_capacity(CNT_W'(phase_cap[p]));
      tx_idle  = (p % 3 != 0);
      rx_burst = (p % 2 == 0);
      key_pool[0] = $urandom;
      key_pool[1] = $signed($urandom_range(0, 15)) - 8;
      key_pool[2] = (p % 2 == 0) ? KEY_MAX : KEY_MIN;
      for (int j = 3; j < POOL_SIZE; j++) key_pool[j] = $urandom;
      for (int i = 0; i < OPS_PER_PHASE; i++) begin
        op = ($urandom_range(0, 99) < phase_ins_pct[p]) ? CMD_INSERT : CMD_DELETE;
        if ($urandom_range(0, 99) < 80) k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        else k = $urandom;
        queue_table_op(op, k);
      end
      wait_table_drained();
    end

    // tail: let any stray result show up
    repeat (10) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/stid_pkg.sv
design/stid_cell.sv
design/sorted_table_insert_delete.sv
design/stid_checker.sv
dv/sorted_table_insert_delete_tb.sv
